>>> rtl/core/pra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pra_pkg;

    // Defaults for the top-level parameters
    localparam int HEAP_PAGES_DEF = 64;
    localparam int SLOT_BITS_DEF  = 32;

    // Fixed field widths
    localparam int CNT_W   = 7;   // count field
    localparam int PAGE_W  = 6;   // page / start_page fields
    localparam int START_W = 6;   // bit position inside a slot (slot width up to 64)

    // Request kinds carried on tuser
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // First-fit search result for one slot
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
    } t_fit;

endpackage

`default_nettype wire

>>> rtl/core/pra_run_find.sv
`timescale 1ns / 1ps
`default_nettype none

// First-fit search for a run of set bits of a given length inside one slot.
// A run of length n is built from power-of-two run masks:
// R(2^j + L)[b] = R(2^j)[b] & R(L)[b + 2^j], so every shift is a constant.
// The accumulated masks carry one extra position just past the slot, where
// only the empty run exists, so runs that end on the last bit are found.
module pra_run_find #(
    parameter int SLOT_BITS = pra_pkg::SLOT_BITS_DEF
) (
    input  logic [SLOT_BITS-1:0]      i_word,
    input  logic [pra_pkg::CNT_W-1:0] i_cnt,
    output pra_pkg::t_fit             o_fit
);
    import pra_pkg::*;

    logic [SLOT_BITS-1:0] w_pow [CNT_W+1];  // runs of length 2^j start here
    logic [SLOT_BITS:0]   w_acc [CNT_W+1];  // runs of the low j bits of count
    logic [SLOT_BITS-1:0] w_hit;

    // Run masks, one doubling step per count bit
    always_comb begin
        w_pow[0] = i_word;
        w_acc[0] = '1;
        for (int j = 0; j < CNT_W; j++) begin
            w_pow[j+1] = w_pow[j] & (w_pow[j] >> (1 << j));
            w_acc[j+1] = i_cnt[j] ? ({1'b0, w_pow[j]} & (w_acc[j] >> (1 << j))) : w_acc[j];
        end
    end

    assign w_hit = w_acc[CNT_W][SLOT_BITS-1:0];

    // Lowest start position wins
    always_comb begin
        o_fit.found = |w_hit;
        o_fit.start = '0;
        for (int i = SLOT_BITS - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                o_fit.start = START_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/page_run_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Page run allocator. Each request on the slave stream (tuser = op, 0 allocate,
// 1 free) gives exactly one response on the master stream. Allocation draws
// from a bump counter while the whole run fits; after that the counter sits at
// HEAP_PAGES and a first-fit search runs over the freed-page bitmap, one slot
// of SLOT_BITS pages at a time, and only finds runs inside one slot. Free sets
// the bitmap bits of the given pages; pages beyond the heap are ignored. One
// request is handled at a time. From S_DECIDE, a bump allocation, a zero
// count or a run longer than a slot goes straight to S_RESP; a bitmap search
// steps through S_RD, S_EV and S_FIT per slot scanned (read wait, search,
// write-back through the single-port bitmap memory with its registered read);
// a free steps through S_RD and S_EV per slot read, reading every slot that
// begins below the end of the run plus the following slot when there is one.
// S_RESP loads the response register once that register is free, so a
// response held by the master stream delays the next load. The next request
// is accepted as soon as the response is in the output register.
module page_run_allocator_core #(
    parameter int HEAP_PAGES = pra_pkg::HEAP_PAGES_DEF,
    parameter int SLOT_BITS  = pra_pkg::SLOT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [6:0] count, [12:7] start_page
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] page
    output logic        m_axis_tuser    // [0] ok
);
    import pra_pkg::*;

    localparam int NUM_SLOTS = (HEAP_PAGES + SLOT_BITS - 1) / SLOT_BITS;
    localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int BW        = $clog2(HEAP_PAGES + 1);
    localparam int AW        = $clog2(HEAP_PAGES + SLOT_BITS);
    localparam int EW        = (AW > 8) ? AW : 8;
    localparam int SUMW      = ((BW > CNT_W) ? BW : CNT_W) + 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_RD     = 6'b000100,
        S_EV     = 6'b001000,
        S_FIT    = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_op, n_op;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [PAGE_W-1:0]    r_first, n_first;
    logic [EW-1:0]        r_end, n_end;
    logic [BW-1:0]        r_bump, n_bump;
    logic [SW-1:0]        r_slot, n_slot;
    logic [EW-1:0]        r_base, n_base;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    t_fit                 r_fit, n_fit;
    logic [SLOT_BITS-1:0] r_word, n_word;
    logic [PAGE_W-1:0]    r_res_page, n_res_page;
    logic                 r_res_ok, n_res_ok;
    logic                 r_out_valid, n_out_valid;
    logic [PAGE_W-1:0]    r_out_page, n_out_page;
    logic                 r_out_ok, n_out_ok;

    // Bitmap memory
    logic [SLOT_BITS-1:0] mem [NUM_SLOTS];
    logic [SLOT_BITS-1:0] r_rdata;
    logic                 r_rd_vld;

    logic                 w_accept;
    logic [SLOT_BITS-1:0] w_word;
    t_fit                 w_fit;
    logic [SUMW-1:0]      w_sum;
    logic                 w_fits;
    logic [EW-1:0]        w_end_raw;
    logic [SLOT_BITS-1:0] w_fmask;
    logic [SLOT_BITS-1:0] w_amask;
    logic [7:0]           w_alo;
    logic [7:0]           w_ahi;
    logic                 w_last;
    logic                 w_we;
    logic [SLOT_BITS-1:0] w_wdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Never-written slots read as empty
    assign w_word = r_rd_vld ? r_rdata : '0;

    pra_run_find #(
        .SLOT_BITS(SLOT_BITS)
    ) u_find (
        .i_word(w_word),
        .i_cnt (r_cnt),
        .o_fit (w_fit)
    );

    // Bump path check, unclipped end of a free run and last-slot flag
    assign w_sum     = SUMW'(r_bump) + SUMW'(r_cnt);
    assign w_fits    = (w_sum <= SUMW'(HEAP_PAGES));
    assign w_end_raw = EW'(r_first) + EW'(r_cnt);
    assign w_last    = (r_slot == SW'(NUM_SLOTS - 1));

    // Free mask: pages of this slot inside [first, end)
    always_comb begin
        for (int i = 0; i < SLOT_BITS; i++) begin
            w_fmask[i] = ((r_base + EW'(i)) >= EW'(r_first)) &&
                         ((r_base + EW'(i)) < r_end);
        end
    end

    // Allocate mask: bits [start, start + count) of this slot
    assign w_alo = 8'(r_fit.start);
    assign w_ahi = w_alo + 8'(r_cnt);
    always_comb begin
        for (int i = 0; i < SLOT_BITS; i++) begin
            w_amask[i] = (8'(i) >= w_alo) && (8'(i) < w_ahi);
        end
    end

    // Request sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_first     = r_first;
        n_end       = r_end;
        n_bump      = r_bump;
        n_slot      = r_slot;
        n_base      = r_base;
        n_valid     = r_valid;
        n_fit       = r_fit;
        n_word      = r_word;
        n_res_page  = r_res_page;
        n_res_ok    = r_res_ok;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_page  = r_out_page;
        n_out_ok    = r_out_ok;
        w_we        = 1'b0;
        w_wdata     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = s_axis_tuser;
                    n_cnt   = s_axis_tdata[6:0];
                    n_first = s_axis_tdata[12:7];
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_slot     = '0;
                n_base     = '0;
                n_res_page = '0;
                if (r_op == OP_FREE) begin
                    n_res_ok = 1'b1;
                    n_end    = (w_end_raw < EW'(HEAP_PAGES)) ? w_end_raw : EW'(HEAP_PAGES);
                    n_state  = S_RD;
                end else if (r_cnt == '0) begin
                    n_res_ok = 1'b0;
                    n_state  = S_RESP;
                end else if (w_fits) begin
                    n_res_page = PAGE_W'(r_bump);
                    n_res_ok   = 1'b1;
                    n_bump     = BW'(w_sum);
                    n_state    = S_RESP;
                end else begin
                    n_bump   = BW'(HEAP_PAGES);
                    n_res_ok = 1'b0;
                    if (8'(r_cnt) > 8'(SLOT_BITS)) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                // memory read of r_slot in flight
                n_state = S_EV;
            end
            S_EV: begin
                if (r_op == OP_FREE) begin
                    if (r_base >= r_end) begin
                        n_state = S_RESP;
                    end else begin
                        w_we            = 1'b1;
                        w_wdata         = w_word | w_fmask;
                        n_valid[r_slot] = 1'b1;
                        if (w_last) begin
                            n_state = S_RESP;
                        end else begin
                            n_slot  = r_slot + SW'(1);
                            n_base  = r_base + EW'(SLOT_BITS);
                            n_state = S_RD;
                        end
                    end
                end else begin
                    n_fit   = w_fit;
                    n_word  = w_word;
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (r_fit.found) begin
                    w_we            = 1'b1;
                    w_wdata         = r_word & ~w_amask;
                    n_valid[r_slot] = 1'b1;
                    n_res_page      = PAGE_W'(r_base + EW'(r_fit.start));
                    n_res_ok        = 1'b1;
                    n_state         = S_RESP;
                end else if (w_last) begin
                    n_state = S_RESP;
                end else begin
                    n_slot  = r_slot + SW'(1);
                    n_base  = r_base + EW'(SLOT_BITS);
                    n_state = S_RD;
                end
            end
            S_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_page  = r_res_page;
                    n_out_ok    = r_res_ok;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bump      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bump      <= n_bump;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= r_valid[r_slot];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_cnt      <= n_cnt;
        r_first    <= n_first;
        r_end      <= n_end;
        r_slot     <= n_slot;
        r_base     <= n_base;
        r_fit      <= n_fit;
        r_word     <= n_word;
        r_res_page <= n_res_page;
        r_res_ok   <= n_res_ok;
        r_out_page <= n_out_page;
        r_out_ok   <= n_out_ok;
    end

    // Bitmap memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_slot] <= w_wdata;
        end
        r_rdata <= mem[r_slot];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - PAGE_W){1'b0}}, r_out_page};
    assign m_axis_tuser  = r_out_ok;

    // Checks
    a_bump_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump <= BW'(HEAP_PAGES))
        else $error("bump count above heap size");

    a_fit_in_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIT && r_fit.found) |-> (w_ahi <= 8'(SLOT_BITS)))
        else $error("allocated run leaves its slot");

    a_resp_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && (!r_out_valid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("response not presented");

    a_wr_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_valid[$past(r_slot)])
        else $error("written slot not marked valid");

endmodule

`default_nettype wire

>>> dv/page_run_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the page run allocator, keeps its own copy of the
// bump counter and the freed-page bitmap, and compares every response with
// the grant predicted for the oldest outstanding request.
module page_run_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_req_data,    // [6:0] count, [12:7] start_page
    input  logic        i_req_user,    // [0] op
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [7:0]  i_rsp_data,    // [5:0] page
    input  logic        i_rsp_user,    // [0] ok
    output int          o_fail_count,
    output int          o_pending
);
    import pra_pkg::*;

    localparam int HEAP   = HEAP_PAGES_DEF;
    localparam int SLOT   = SLOT_BITS_DEF;
    localparam int NSLOTS = (HEAP + SLOT - 1) / SLOT;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              ok;
    } t_grant;

    logic [CNT_W-1:0] bump_pages;
    logic [SLOT-1:0]  freed_map [NSLOTS];
    t_grant           grants_due [$];
    int               mismatches;
    int               outstanding;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    // Bump path while the whole run fits, then first-fit inside one slot
    task automatic run_alloc(input logic [CNT_W-1:0] need, output t_grant g);
        int run_len;
        int run_start;
        int k;
        g = '0;
        if (need == 0) return;
        if (int'(bump_pages) + int'(need) <= HEAP) begin
            g.page     = bump_pages[PAGE_W-1:0];
            g.ok       = 1'b1;
            bump_pages = bump_pages + need;
            return;
        end
        // overflow gives up the remaining bump pages
        bump_pages = CNT_W'(HEAP);
        if (int'(need) > SLOT) return;
        for (int s = 0; s < NSLOTS; s++) begin
            run_len   = 0;
            run_start = 0;
            for (int b = 0; b < SLOT; b++) begin
                if (freed_map[s][b]) begin
                    if (run_len == 0) run_start = b;
                    run_len++;
                    if (run_len == int'(need)) begin
                        for (k = run_start; k <= b; k++) freed_map[s][k] = 1'b0;
                        g.page = PAGE_W'(s * SLOT + run_start);
                        g.ok   = 1'b1;
                        return;
                    end
                end else begin
                    run_len = 0;
                end
            end
        end
    endtask

    // Mark pages freed; pages past the heap fall away
    task automatic run_free(input logic [PAGE_W-1:0] first, input logic [CNT_W-1:0] cnt);
        int p;
        for (int i = 0; i < int'(cnt); i++) begin
            p = int'(first) + i;
            if (p < HEAP) freed_map[p / SLOT][p % SLOT] = 1'b1;
        end
    endtask

    // Compare responses first, then predict the request taken at this edge
    always @(posedge i_clk) begin
        t_grant want;
        t_grant got;
        if (!i_rst_n) begin
            bump_pages = '0;
            for (int s = 0; s < NSLOTS; s++) freed_map[s] = '0;
            grants_due.delete();
            outstanding = 0;
            mismatches  = mismatches;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got.page = i_rsp_data[PAGE_W-1:0];
                got.ok   = i_rsp_user;
                if (grants_due.size() == 0) begin
                    $display("%0t: response with no request outstanding: page %0d ok %0d",
                             $time, got.page, got.ok);
                    mismatches++;
                end else begin
                    want = grants_due.pop_front();
                    outstanding--;
                    if (got.page !== want.page) begin
                        $display("%0t: page mismatch: expected %0d, actual %0d",
                                 $time, want.page, got.page);
                        mismatches++;
                    end
                    if (got.ok !== want.ok) begin
                        $display("%0t: ok mismatch: expected %0d, actual %0d",
                                 $time, want.ok, got.ok);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_user == OP_FREE) begin
                    run_free(i_req_data[CNT_W +: PAGE_W], i_req_data[CNT_W-1:0]);
                    want.page = '0;
                    want.ok   = 1'b1;
                end else begin
                    run_alloc(i_req_data[CNT_W-1:0], want);
                end
                grants_due.push_back(want);
                outstanding++;
            end
        end
    end

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

// Drives allocate and free requests into the page run allocator with random
// gaps and response stalls; the checker predicts and compares each response.
module tb;
    import pra_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // [6:0] count, [12:7] start_page
    logic        s_axis_tuser;     // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // [5:0] page
    logic        m_axis_tuser;     // [0] ok

    int          fail_count;
    int          pending;
    bit          jitter_on;
    bit          hold_rsp;

    logic        op;
    logic [6:0]  cnt;
    int          pick;

    page_run_allocator_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    page_run_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Offer one request and hold it until taken; returns at a falling edge
    task automatic send_request(input logic kind, input logic [6:0] pages,
                                input logic [5:0] first);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {3'b000, first, pages};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Short random gap after a request
    task automatic sender_gap();
        if (jitter_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Response side: random short stalls, one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_rsp) begin
                m_axis_tready = 1'b0;
                repeat (60) @(negedge clk);
                hold_rsp = 1'b0;
            end else if (jitter_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ALLOC;
        rst_n         = 1'b0;
        jitter_on     = 1'b0;
        hold_rsp      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n     = 1'b1;
        jitter_on = 1'b1;

        // zero counts, bump path, bump overflow with an empty bitmap
        send_request(OP_ALLOC, 7'd0, 6'd0);
        send_request(OP_FREE, 7'd0, 6'd5);
        send_request(OP_ALLOC, 7'd1, 6'd63);
        send_request(OP_ALLOC, 7'd60, 6'd0);
        sender_gap();
        send_request(OP_ALLOC, 7'd5, 6'd0);
        // freed run straddling the slot boundary is not joined
        send_request(OP_FREE, 7'd4, 6'd30);
        send_request(OP_ALLOC, 7'd4, 6'd0);
        send_request(OP_ALLOC, 7'd2, 6'd0);
        sender_gap();
        send_request(OP_ALLOC, 7'd2, 6'd0);
        // free running past the heap end, then whole-slot runs
        send_request(OP_FREE, 7'd127, 6'd0);
        send_request(OP_ALLOC, 7'd32, 6'd0);
        send_request(OP_ALLOC, 7'd33, 6'd0);
        send_request(OP_ALLOC, 7'd64, 6'd0);
        send_request(OP_ALLOC, 7'd127, 6'd0);
        send_request(OP_ALLOC, 7'd32, 6'd0);
        sender_gap();
        send_request(OP_ALLOC, 7'd1, 6'd0);
        send_request(OP_FREE, 7'd64, 6'd63);
        send_request(OP_ALLOC, 7'd1, 6'd0);
        send_request(OP_FREE, 7'd10, 6'd42);
        send_request(OP_FREE, 7'd1, 6'd21);
        send_request(OP_ALLOC, 7'd3, 6'd0);
        send_request(OP_ALLOC, 7'd1, 6'd0);
        wait_drained();

        // random mix over the bitmap, broken into jittered and quiet stretches
        for (int k = 0; k < 500; k++) begin
            jitter_on = (k < 420) && ((k / 40) % 3 != 2);
            if (k == 200) hold_rsp = 1'b1;
            if (k == 300) wait_drained();
            op   = ($urandom_range(0, 99) < 50) ? OP_FREE : OP_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 3)       cnt = 7'd0;
            else if (pick < 8)  cnt = 7'($urandom_range(33, 127));
            else if (pick < 20) cnt = 7'($urandom_range(9, 32));
            else                cnt = 7'($urandom_range(1, 8));
            send_request(op, cnt, 6'($urandom));
            sender_gap();
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> page_run_allocator_core.f
rtl/core/pra_pkg.sv
rtl/core/pra_run_find.sv
rtl/core/page_run_allocator_core.sv
dv/page_run_checker.sv
dv/tb.sv
